// ===== rtl/core/lz77_pkg.sv =====
`timescale 1ns / 1ps

package lz77_pkg;

  localparam int SEARCH_SIZE_DEF    = 256;
  localparam int LOOKAHEAD_SIZE_DEF = 16;

  localparam int SL_W  = 9;   // search_limit width
  localparam int ML_W  = 4;   // match_limit width
  localparam int OFF_W = 9;
  localparam int LEN_W = 4;

  localparam logic [SL_W-1:0] SEARCH_LIMIT_RST = 9'd5;
  localparam logic [ML_W-1:0] MATCH_LIMIT_RST  = 4'd15;

  localparam logic [1:0] CFG_SEARCH_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MATCH_LIMIT  = 2'd1;

  // one input word held in the front queue
  typedef struct packed {
    logic       eoi;
    logic [7:0] data_byte;
  } item_t;

  // one token
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [7:0]       next_byte;
    logic             has_byte;
    logic             last;
  } token_t;

endpackage

// ===== rtl/core/lz77_front.sv =====
`timescale 1ns / 1ps

// Two-entry word queue between the input port and the encoder engine.
module lz77_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lz77_pkg::item_t   in_item,
  output logic              q_valid,
  input  logic              q_ready,
  output lz77_pkg::item_t   q_item
);

  lz77_pkg::item_t mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

// ===== rtl/core/lz77_engine.sv =====
`timescale 1ns / 1ps

// Back end: lookahead queue, history memory, sequential match search and
// token output register.
module lz77_engine #(
  parameter int SEARCH_SIZE    = lz77_pkg::SEARCH_SIZE_DEF,
  parameter int LOOKAHEAD_SIZE = lz77_pkg::LOOKAHEAD_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lz77_pkg::SL_W-1:0]   search_limit,
  input  logic [lz77_pkg::ML_W-1:0]   match_limit,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  lz77_pkg::item_t             q_item,
  output logic                        tok_valid,
  input  logic                        tok_ready,
  output lz77_pkg::token_t            tok
);

  localparam int SW  = (SEARCH_SIZE > 2) ? $clog2(SEARCH_SIZE) : 1;
  localparam int FW  = $clog2(SEARCH_SIZE + 1);
  localparam int WW  = (FW > lz77_pkg::SL_W) ? FW : lz77_pkg::SL_W;
  localparam int CW  = $clog2(LOOKAHEAD_SIZE + 1);
  localparam int PAW = (LOOKAHEAD_SIZE > 2) ? $clog2(LOOKAHEAD_SIZE) : 1;
  localparam int LW  = lz77_pkg::LEN_W;
  localparam int MMAX_I = (LOOKAHEAD_SIZE - 1 < 15) ? (LOOKAHEAD_SIZE - 1) : 15;
  localparam logic [LW-1:0] MMAX = LW'(MMAX_I);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_REF   = 4'd2;
  localparam logic [3:0] ST_CAND  = 4'd3;
  localparam logic [3:0] ST_CMP   = 4'd4;
  localparam logic [3:0] ST_NEXT  = 4'd5;
  localparam logic [3:0] ST_EMIT  = 4'd6;
  localparam logic [3:0] ST_SHIFT = 4'd7;

  logic [3:0]    st_r, st_nxt;
  logic [7:0]    pend_r [LOOKAHEAD_SIZE];
  logic [CW-1:0] cnt_r;
  logic          flush_r;
  logic [SW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] win_r, d_r, boff_r;
  logic [LW-1:0] lim_r, len_r, best_r;
  logic [CW-1:0] sh_r;
  logic [7:0]    ref_r, rd_q, hist_q;
  logic [7:0]    hist_mem [SEARCH_SIZE];
  lz77_pkg::token_t tok_r;
  logic          tok_valid_r;

  logic [PAW-1:0] p_addr;
  logic [SW-1:0]  h_addr;
  logic [FW:0]    h_sum;
  logic [FW-1:0]  back;
  logic [WW-1:0]  s1, s_eff;
  logic [FW-1:0]  window;
  logic [LW-1:0]  em, lim;
  logic [7:0]     cand;
  logic           has;
  logic [CW-1:0]  used;
  logic           tok_free;

  assign q_ready   = (st_r == ST_IDLE);
  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;
  assign tok_free  = !tok_valid_r || tok_ready;

  // effective limits
  always_comb begin
    s1 = (search_limit == '0) ? WW'(1) : WW'(search_limit);
    s_eff = (s1 > WW'(SEARCH_SIZE)) ? WW'(SEARCH_SIZE) : s1;
    window = (s_eff > WW'(fill_r)) ? fill_r : FW'(s_eff);
    em = (match_limit == '0) ? LW'(1) : match_limit;
    if (em > MMAX) em = MMAX;
    lim = (CW'(em) > cnt_r) ? LW'(cnt_r) : em;
  end

  // history address of candidate byte: head - (d - len), modulo size
  always_comb begin
    back  = d_r - FW'(len_r);
    h_sum = (FW+1)'(head_r) + (FW+1)'(SEARCH_SIZE) - (FW+1)'(back);
    if (h_sum >= (FW+1)'(SEARCH_SIZE)) h_sum = h_sum - (FW+1)'(SEARCH_SIZE);
    h_addr = SW'(h_sum);
  end

  always_comb begin
    case (st_r)
      ST_REF:  p_addr = PAW'(len_r);
      ST_CAND: p_addr = PAW'(len_r - LW'(d_r));
      default: p_addr = PAW'(best_r);
    endcase
  end

  assign cand = (FW'(len_r) < d_r) ? hist_q : rd_q;
  assign has  = (CW'(best_r) < cnt_r);
  assign used = CW'(best_r) + CW'(has);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (q_valid) st_nxt = ST_CHECK;
      ST_CHECK: begin
        if (flush_r ? (cnt_r != '0) : (cnt_r >= CW'(em) + CW'(1))) begin
          st_nxt = (window == '0) ? ST_NEXT : ST_REF;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_REF:   st_nxt = (len_r < lim_r) ? ST_CAND : ST_CMP;
      ST_CAND:  st_nxt = ST_CMP;
      ST_CMP:   begin
        if (len_r < lim_r && cand == ref_r && len_r + LW'(1) < lim_r) st_nxt = ST_REF;
        else if (d_r == win_r) st_nxt = ST_NEXT;
        else st_nxt = ST_REF;
      end
      ST_NEXT:  st_nxt = ST_EMIT;
      ST_EMIT:  if (tok_free) st_nxt = ST_SHIFT;
      ST_SHIFT: if (sh_r == CW'(1)) st_nxt = ST_CHECK;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      flush_r     <= 1'b0;
      tok_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (tok_valid_r && tok_ready && st_r != ST_EMIT) tok_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (cnt_r < CW'(LOOKAHEAD_SIZE)) begin
              pend_r[PAW'(cnt_r)] <= q_item.data_byte;
              cnt_r <= cnt_r + CW'(1);
            end
            flush_r <= q_item.eoi;
          end
        end
        ST_CHECK: begin
          // start a token, or close the stream after the flush
          win_r  <= window;
          lim_r  <= lim;
          d_r    <= FW'(1);
          len_r  <= '0;
          best_r <= '0;
          boff_r <= '0;
          if (flush_r && cnt_r == '0) begin
            head_r  <= '0;
            fill_r  <= '0;
            flush_r <= 1'b0;
          end
        end
        ST_CAND: begin
          // queue byte at the current match position
          ref_r <= rd_q;
        end
        ST_CMP: begin
          if (len_r < lim_r && cand == ref_r && len_r + LW'(1) < lim_r) begin
            len_r <= len_r + LW'(1);
          end else begin
            // candidate done: keep the nearest of equal lengths
            if (len_r < lim_r && cand == ref_r) begin
              if (len_r + LW'(1) > best_r) begin
                best_r <= len_r + LW'(1);
                boff_r <= d_r;
              end
            end else if (len_r > best_r) begin
              best_r <= len_r;
              boff_r <= d_r;
            end
            len_r <= '0;
            if (d_r != win_r) d_r <= d_r + FW'(1);
          end
        end
        ST_EMIT: begin
          if (tok_free) begin
            tok_valid_r        <= 1'b1;
            tok_r.offset       <= lz77_pkg::OFF_W'(boff_r);
            tok_r.length       <= best_r;
            tok_r.next_byte    <= has ? rd_q : 8'd0;
            tok_r.has_byte     <= has;
            tok_r.last         <= flush_r && (used == cnt_r);
            sh_r               <= used;
          end
        end
        ST_SHIFT: begin
          // move one consumed byte into the history
          for (int i = 0; i < LOOKAHEAD_SIZE - 1; i++) pend_r[i] <= pend_r[i+1];
          cnt_r  <= cnt_r - CW'(1);
          sh_r   <= sh_r - CW'(1);
          head_r <= (head_r == SW'(SEARCH_SIZE - 1)) ? '0 : head_r + SW'(1);
          if (fill_r != FW'(SEARCH_SIZE)) fill_r <= fill_r + FW'(1);
        end
        default: ;
      endcase
    end
  end

  // registered reads of queue and history
  always_ff @(posedge clk) begin
    rd_q <= pend_r[p_addr];
    if (st_r == ST_SHIFT) begin
      hist_mem[head_r] <= pend_r[0];
    end
    hist_q <= hist_mem[h_addr];
  end

endmodule

// ===== rtl/core/lz77_token_encoder_unit.sv =====
`timescale 1ns / 1ps
// Flow: an input word that completes a token yields it once the engine has
//   searched the window candidate by candidate and the token register is free.
// Throughput: one word at a time through the engine; the search is sequential,
//   each compared byte passing through the REF, CAND and CMP states in turn.
// Reset: synchronous, active low; clears queue, counts and output valid.
module lz77_token_encoder_unit #(
  parameter int SEARCH_SIZE    = lz77_pkg::SEARCH_SIZE_DEF,
  parameter int LOOKAHEAD_SIZE = lz77_pkg::LOOKAHEAD_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_input
  // tokens
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] offset, [12:9] length,
                                  // [20:13] next_byte, [21] has_byte
  output logic        out_tlast,  // last
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [lz77_pkg::SL_W-1:0] search_limit_r;
  logic [lz77_pkg::ML_W-1:0] match_limit_r;
  lz77_pkg::item_t  in_item, q_item;
  lz77_pkg::token_t tok;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // hold register values; reset restores defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_limit_r <= lz77_pkg::SEARCH_LIMIT_RST;
      match_limit_r  <= lz77_pkg::MATCH_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lz77_pkg::CFG_SEARCH_LIMIT: search_limit_r <= cfg_data;
        lz77_pkg::CFG_MATCH_LIMIT:  match_limit_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_item.data_byte = in_tdata;
  assign in_item.eoi       = in_tlast;

  // front queue decouples the input port from the search engine
  lz77_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  lz77_engine #(
    .SEARCH_SIZE    (SEARCH_SIZE),
    .LOOKAHEAD_SIZE (LOOKAHEAD_SIZE)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .search_limit (search_limit_r),
    .match_limit  (match_limit_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .tok_valid    (out_tvalid),
    .tok_ready    (out_tready),
    .tok          (tok)
  );

  assign out_tdata = {2'b00, tok.has_byte, tok.next_byte, tok.length, tok.offset};
  assign out_tlast = tok.last;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int HIST_N    = 256;
  localparam int LOOK_N    = 16;
  localparam int CYCLE_CAP = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = lz77_pkg::CFG_SEARCH_LIMIT;
  logic [8:0]  cfg_data = '0;

  lz77_token_encoder_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Words waiting to be sent, tokens still owed by the encoder.
  lz77_pkg::item_t  word_q[$];
  lz77_pkg::token_t token_q[$];

  // Shadow encoder state: history ring, lookahead queue and registers.
  logic [7:0]      hist_mem[HIST_N];
  int unsigned     hist_fill = 0;
  int unsigned     hist_head = 0;
  logic [7:0]      look_mem[LOOK_N];
  int unsigned     look_cnt = 0;
  logic [lz77_pkg::SL_W-1:0] sh_search = lz77_pkg::SEARCH_LIMIT_RST;
  logic [lz77_pkg::ML_W-1:0] sh_match  = lz77_pkg::MATCH_LIMIT_RST;

  int  n_fail = 0;
  int  n_words = 0;
  int  n_tokens = 0;
  int  n_streams = 0;
  int  n_cycles = 0;
  bit  in_acc = 1'b0;
  bit  no_idle = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  function automatic int unsigned window_size();
    int unsigned s;
    s = 32'(sh_search);
    if (s < 1) s = 1;
    if (s > HIST_N) s = HIST_N;
    return s;
  endfunction

  function automatic int unsigned match_cap();
    int unsigned m;
    m = 32'(sh_match);
    if (m < 1) m = 1;
    if (m > LOOK_N - 1) m = LOOK_N - 1;
    return m;
  endfunction

  // Byte k of a candidate starting d bytes before the lookahead head.
  function automatic logic [7:0] cand_at(int unsigned d, int unsigned k);
    if (k < d) return hist_mem[(hist_head + HIST_N - (d - k)) % HIST_N];
    return (k - d < LOOK_N) ? look_mem[k - d] : 8'h00;
  endfunction

  // Find the longest (nearest on a tie) match at the head and owe its token.
  function automatic void encode_token(bit flushing);
    int unsigned win, cap, best_len, best_off, len, used;
    lz77_pkg::token_t t;
    win = window_size();
    cap = match_cap();
    best_len = 0;
    best_off = 0;
    if (win > hist_fill) win = hist_fill;
    if (flushing && cap > look_cnt) cap = look_cnt;
    for (int unsigned d = 1; d <= win; d++) begin
      len = 0;
      while (len < cap && len < look_cnt && cand_at(d, len) == look_mem[len]) len++;
      if (len > best_len) begin
        best_len = len;
        best_off = d;
      end
    end
    t.offset = best_off[lz77_pkg::OFF_W-1:0];
    t.length = best_len[lz77_pkg::LEN_W-1:0];
    t.has_byte = (best_len < look_cnt);
    t.next_byte = t.has_byte ? look_mem[best_len] : 8'h00;
    used = best_len + 32'(t.has_byte);
    if (used > look_cnt) used = look_cnt;
    t.last = flushing && (used == look_cnt);
    for (int unsigned i = 0; i < used; i++) begin
      hist_mem[hist_head] = look_mem[i];
      hist_head = (hist_head + 1) % HIST_N;
      if (hist_fill < HIST_N) hist_fill++;
    end
    for (int unsigned i = 0; i + used < look_cnt; i++) look_mem[i] = look_mem[i + used];
    look_cnt -= used;
    token_q.push_back(t);
  endfunction

  function automatic void clear_stream();
    hist_fill = 0;
    hist_head = 0;
    look_cnt = 0;
  endfunction

  // One accepted word: queue it, then emit what it makes due.
  function automatic void predict_word(lz77_pkg::item_t w);
    int n;
    n = 0;
    if (look_cnt < LOOK_N) begin
      look_mem[look_cnt] = w.data_byte;
      look_cnt++;
    end
    if (w.eoi) begin
      while (look_cnt > 0 && n < LOOK_N) begin
        encode_token(1'b1);
        n++;
      end
      clear_stream();
    end else begin
      while (look_cnt >= match_cap() + 1 && n < LOOK_N) begin
        encode_token(1'b0);
        n++;
      end
    end
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Sample at the rising edge: predict on accepted words, check tokens.
  always @(posedge clk) begin
    lz77_pkg::token_t got, want;
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d tokens outstanding", $time, token_q.size());
      $display("== FAIL ==");
      $finish;
    end else if (rst_n) begin
      in_acc <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lz77_pkg::CFG_SEARCH_LIMIT) sh_search = cfg_data;
        else if (cfg_index == lz77_pkg::CFG_MATCH_LIMIT)
          sh_match = cfg_data[lz77_pkg::ML_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        predict_word('{eoi: in_tlast, data_byte: in_tdata});
        n_words++;
        if (in_tlast) n_streams++;
      end
      if (out_tvalid && out_tready) begin
        got = '{offset: out_tdata[8:0], length: out_tdata[12:9],
                next_byte: out_tdata[20:13], has_byte: out_tdata[21], last: out_tlast};
        n_tokens++;
        if (token_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected token, actual %p", $time, got);
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            n_fail++;
            $display("%0t: token mismatch, expected %p, actual %p", $time, want, got);
          end
        end
      end
    end
  end

  // Drive the input side at the falling edge; hold a word until taken.
  always @(negedge clk) begin
    lz77_pkg::item_t w;
    if (rst_n && !(in_tvalid && !in_acc)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        w = word_q.pop_front();
        in_tdata <= w.data_byte;
        in_tlast <= w.eoi;
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the token side at random.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  function automatic void push_word(logic [7:0] b, bit eoi);
    word_q.push_back('{eoi: eoi, data_byte: b});
  endfunction

  // Random stream: mostly a small alphabet so matches form, some raw bytes.
  function automatic void push_stream(int len, bit terminate);
    logic [7:0] base;
    int alpha;
    base = 8'($urandom_range(255));
    alpha = $urandom_range(4, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) push_word(8'($urandom_range(255)), terminate && i == len - 1);
      else push_word(8'(base + $urandom_range(alpha - 1)), terminate && i == len - 1);
    end
  endfunction

  // Hold until every word has gone and every token has come, then let the
  // search engine settle for a time that grows with the current window.
  task automatic drain();
    int unsigned settle;
    while (word_q.size() > 0 || in_tvalid || token_q.size() > 0) @(posedge clk);
    settle = 2 * window_size() * LOOK_N + 32;
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: lone byte stream, byte extremes, a repeating pattern and a
    // run long enough to hit the match cap, all at reset settings.
    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b0);
    push_word(8'h55, 1'b0);
    push_word(8'hAA, 1'b1);
    for (int i = 0; i < 9; i++) push_word(8'(8'h61 + i % 3), i == 8);
    for (int i = 0; i < 20; i++) push_word(8'h7A, i == 19);
    drain();

    // Smallest window and match cap.
    write_reg(lz77_pkg::CFG_SEARCH_LIMIT, 9'd1);
    write_reg(lz77_pkg::CFG_MATCH_LIMIT, 9'd1);
    no_idle = 1'b1;
    for (int s = 0; s < 4; s++) push_stream($urandom_range(6, 2), 1'b1);
    drain();

    // Largest window over a repetitive stream.
    write_reg(lz77_pkg::CFG_SEARCH_LIMIT, 9'd256);
    write_reg(lz77_pkg::CFG_MATCH_LIMIT, 9'd15);
    no_idle = 1'b0;
    push_stream(40, 1'b1);
    drain();

    // Leave a stream open, lower the match cap, then carry on.
    write_reg(lz77_pkg::CFG_SEARCH_LIMIT, 9'd8);
    push_stream(12, 1'b0);
    drain();
    write_reg(lz77_pkg::CFG_MATCH_LIMIT, 9'd3);
    push_stream(10, 1'b1);
    drain();

    // Random settings and streams, some left open across phases.
    for (int p = 0; p < 8; p++) begin
      write_reg(lz77_pkg::CFG_SEARCH_LIMIT, 9'($urandom_range(32, 1)));
      write_reg(lz77_pkg::CFG_MATCH_LIMIT, 9'($urandom_range(15, 1)));
      no_idle = (p % 3 == 2);
      for (int s = 0; s < 3; s++) push_stream($urandom_range(3, 1), $urandom_range(4) != 0);
      drain();
    end

    $display("Sent %0d words in %0d closed streams, checked %0d tokens; %0d mismatches.",
             n_words, n_streams, n_tokens, n_fail);
    $display("Windows 1..256 and match caps 1..15 covered, incl. a mid-stream cap change.");
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
